### src/csvf_pkg.sv
// Package for the cascaded state-variable filter: widths, register indexes,
// filter type codes, sequencer step type, configuration struct and arithmetic helpers.
// No dependencies.
package csvf_pkg;

    localparam int MAX_STAGES = 5;
    localparam int NUM_STAGES = MAX_STAGES + 1;
    localparam int STAGE_W    = $clog2(NUM_STAGES);

    localparam int SAMPLE_W = 24;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 21;
    localparam int PROD_W   = ACC_W + COEF_W;
    localparam int SUM_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_F      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Q      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Q_ROOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = 3'd5;

    // Filter type codes; all other codes select the low output.
    localparam logic [2:0] FT_LOW   = 3'd0;
    localparam logic [2:0] FT_HIGH  = 3'd1;
    localparam logic [2:0] FT_BAND  = 3'd2;
    localparam logic [2:0] FT_NOTCH = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LD,
        ST_MBF,
        ST_MBQ,
        ST_MXQ,
        ST_HI,
        ST_MHF,
        ST_WB,
        ST_GM,
        ST_OUT
    } csvf_step_t;

    typedef struct packed {
        logic [15:0]        coef_f;
        logic [16:0]        coef_q;
        logic [16:0]        coef_q_root;
        logic [2:0]         filter_type;
        logic [19:0]        out_gain;
        logic [STAGE_W-1:0] stage_last;
        logic               clear_int;
    } csvf_cfg_t;

    // Round half up and drop 16 fraction bits, sign-extended to the sum width.
    function automatic logic signed [SUM_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return {{(SUM_W - PROD_W + 16){t[PROD_W-1]}}, t[PROD_W-1:16]};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext32(input logic signed [ACC_W-1:0] v);
        return {{(SUM_W - ACC_W){v[ACC_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-ACC_W:0] upper;
        upper = v[SUM_W-1:ACC_W-1];
        if (&upper || ~|upper)
            return v[ACC_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_W:0] upper;
        upper = v[SUM_W-1:SAMPLE_W-1];
        if (&upper || ~|upper)
            return v[SAMPLE_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

### src/cascaded_state_variable_filter.sv
// Top level of the cascaded state-variable filter: configuration registers,
// handshakes and output register. Depends on csvf_pkg and csvf_core.
//
//  Channel   Handshake             Payload                  Direction
//  ------------------------------------------------------------------
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data      in
//  in        in_valid/in_ready     sample_in                in
//  out       out_valid/out_ready   sample_out               out
//
// Each stage runs through one shared multiplier (read, load, three multiplies,
// the high-pass sum, a fourth multiply, write-back). Each word passes stages 0 to
// n (stage_count clamped to MAX_STAGES) and the output gain before the next is taken.
// Reset clears the integrator valid bits at once; no clearing pass is needed.
// The output register holds a finished word while out_ready is low, and the
// next input word is accepted meanwhile; the core stalls only when a second
// result is ready and the output register is still full.
module cascaded_state_variable_filter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [csvf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [csvf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [csvf_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [csvf_pkg::SAMPLE_W-1:0]    sample_out
);
    import csvf_pkg::*;

    logic [15:0] coef_f_reg;
    logic [16:0] coef_q_reg;
    logic [16:0] coef_q_root_reg;
    logic [2:0]  filter_type_reg;
    logic [2:0]  stage_count_reg;
    logic [19:0] out_gain_reg;

    logic out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic       cfg_write;
    logic       core_idle;
    logic       res_valid;
    logic       res_ready;
    logic signed [SAMPLE_W-1:0] res_sample;
    csvf_cfg_t  cfg;

    // Configuration writes are always taken; software writes only while idle, but the block itself does not enforce it.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_f_reg      <= 16'd32768;
            coef_q_reg      <= 17'd65536;
            coef_q_root_reg <= 17'd65536;
            filter_type_reg <= FT_LOW;
            stage_count_reg <= 3'd0;
            out_gain_reg    <= 20'd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COEF_F:      coef_f_reg      <= cfg_data[15:0];
                REG_COEF_Q:      coef_q_reg      <= cfg_data[16:0];
                REG_COEF_Q_ROOT: coef_q_root_reg <= cfg_data[16:0];
                REG_FILTER_TYPE: filter_type_reg <= cfg_data[2:0];
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[2:0];
                REG_OUT_GAIN:    out_gain_reg    <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // A stage count beyond the store is used as the largest one; a write to
    // the stage count clears every integrator.
    always_comb
    begin
        cfg.coef_f      = coef_f_reg;
        cfg.coef_q      = coef_q_reg;
        cfg.coef_q_root = coef_q_root_reg;
        cfg.filter_type = filter_type_reg;
        cfg.out_gain    = out_gain_reg;
        cfg.stage_last  = (32'(stage_count_reg) > MAX_STAGES) ?
                          STAGE_W'(MAX_STAGES) : STAGE_W'(stage_count_reg);
        cfg.clear_int   = cfg_write && (cfg_index == REG_STAGE_COUNT);
    end

    assign in_ready = core_idle;

    csvf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (in_valid && in_ready),
        .sample     (sample_in),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_sample (res_sample)
    );

    // The output register takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            sample_out_reg <= res_sample;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

### src/csvf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module csvf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/csvf_core.sv
// Stage sequencer and shared multiply datapath of the filter cascade.
// Depends on csvf_pkg and csvf_ram (integrator store).
module csvf_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csvf_pkg::csvf_cfg_t                  cfg,
    input  logic                                 start,
    input  logic signed [csvf_pkg::SAMPLE_W-1:0] sample,
    output logic                                 idle,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [csvf_pkg::SAMPLE_W-1:0] res_sample
);
    import csvf_pkg::*;

    csvf_step_t step_reg, step_next;
    logic [STAGE_W-1:0]      stage_reg;
    logic [NUM_STAGES-1:0]   valid_reg;
    logic signed [ACC_W-1:0] x_reg, low_reg, band_reg, lo_reg, hi_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [ACC_W-1:0]  mul_a;
    logic signed [COEF_W-1:0] mul_c;
    logic                     mul_en;
    logic signed [ACC_W-1:0]  bd, nt, x_sel;
    logic                     ram_we, ram_re;
    logic [2*ACC_W-1:0]       ram_rdata;

    // Low integrator in the upper half of a word, band in the lower half.
    csvf_ram #(
        .WIDTH (2 * ACC_W),
        .DEPTH (NUM_STAGES)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (stage_reg),
        .wdata ({lo_reg, bd}),
        .re    (ram_re),
        .raddr (stage_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        step_next = step_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (step_reg)
            ST_IDLE: if (start) step_next = ST_RD;
            ST_RD:
            begin
                ram_re    = 1'b1;
                step_next = ST_LD;
            end
            ST_LD:  step_next = ST_MBF;
            ST_MBF: step_next = ST_MBQ;
            ST_MBQ: step_next = ST_MXQ;
            ST_MXQ: step_next = ST_HI;
            ST_HI:  step_next = ST_MHF;
            ST_MHF: step_next = ST_WB;
            ST_WB:
            begin
                ram_we    = 1'b1;
                step_next = (stage_reg == cfg.stage_last) ? ST_GM : ST_RD;
            end
            ST_GM:  step_next = ST_OUT;
            ST_OUT: if (res_ready) step_next = ST_IDLE;
            default: step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            stage_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (start && step_reg == ST_IDLE)
            begin
                stage_reg <= '0;
            end
            else if (step_reg == ST_WB && stage_reg != cfg.stage_last)
            begin
                stage_reg <= stage_reg + 1'b1;
            end
            if (cfg.clear_int)
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[stage_reg] <= 1'b1;
            end
        end
    end

    // One multiplier, shared by every product of a stage and by the output gain.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = band_reg;
        mul_c  = {5'b0, cfg.coef_f};
        case (step_reg)
            ST_MBF: mul_c = {5'b0, cfg.coef_f};
            ST_MBQ: mul_c = {4'b0, cfg.coef_q};
            ST_MXQ:
            begin
                mul_a = x_reg;
                mul_c = {4'b0, cfg.coef_q_root};
            end
            ST_MHF: mul_a = hi_reg;
            ST_GM:
            begin
                mul_a = x_reg;
                mul_c = {1'b0, cfg.out_gain};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign bd = sat32(ext32(band_reg) + round_q16(prod_reg));
    assign nt = sat32(ext32(hi_reg) + ext32(lo_reg));

    always_comb
    begin
        case (cfg.filter_type)
            FT_HIGH:  x_sel = hi_reg;
            FT_BAND:  x_sel = bd;
            FT_NOTCH: x_sel = nt;
            default:  x_sel = lo_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_c;
        end
        case (step_reg)
            ST_IDLE:
            begin
                x_reg <= {{(ACC_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
            end
            ST_LD:
            begin
                low_reg  <= valid_reg[stage_reg] ? ram_rdata[2*ACC_W-1:ACC_W] : '0;
                band_reg <= valid_reg[stage_reg] ? ram_rdata[ACC_W-1:0] : '0;
            end
            ST_MBQ: lo_reg  <= sat32(ext32(low_reg) + round_q16(prod_reg));
            ST_MXQ: acc_reg <= -ext32(lo_reg) - round_q16(prod_reg);
            ST_HI:  hi_reg  <= sat32(acc_reg + round_q16(prod_reg));
            ST_WB:  x_reg   <= x_sel;
            default: ;
        endcase
    end

    assign idle       = (step_reg == ST_IDLE);
    assign res_valid  = (step_reg == ST_OUT);
    assign res_sample = sat24(round_q16(prod_reg));

`ifndef NO_ASSERTIONS
    a_valid_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_WB) && !cfg.clear_int |=> valid_reg[$past(stage_reg)])
        else $error("integrator entry not marked valid after write-back");

    a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> stage_reg <= cfg.stage_last)
        else $error("stage index beyond configured cascade length");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> !ram_we ##1 !ram_we)
        else $error("write-back overlaps a pending integrator read");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_sample))
        else $error("core result changed while waiting");
`endif

endmodule

### tb/csvf_checker.sv
// Checker for the cascaded state-variable filter: tracks register writes,
// predicts each output word from its own fixed-point filter copy and compares.
// Depends on csvf_pkg.
module csvf_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [csvf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [csvf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [csvf_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [csvf_pkg::SAMPLE_W-1:0]    sample_out,
    output int                                      mismatch_count,
    output int                                      words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;
    import csvf_pkg::*;

    logic [15:0]               f_coef;
    logic [16:0]               q_coef;
    logic [16:0]               q_root_coef;
    logic [2:0]                ftype;
    logic [2:0]                count;
    logic [19:0]               gain;
    logic signed [ACC_W-1:0]   low_int  [NUM_STAGES];
    logic signed [ACC_W-1:0]   band_int [NUM_STAGES];

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         errors = 0;
    int                         in_flight = 0;

    assign mismatch_count  = errors;
    assign words_in_flight = in_flight;

    task automatic flag_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Coefficient product, rounded half up, with 16 fraction bits dropped.
    function automatic longint round_mul(input longint a, input longint c);
        return (a * c + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [ACC_W-1:0] clip_acc(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void clear_integrators();
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            low_int[s]  = '0;
            band_int[s] = '0;
        end
    endfunction

    // Runs one word through the cascade and advances the integrators.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] din);
        longint x;
        longint y;
        int last;
        int s;
        logic signed [ACC_W-1:0] lo, hi, bd, nt;
        x = din;
        last = (count > MAX_STAGES) ? MAX_STAGES : count;
        for (s = 0; s <= last; s++)
        begin
            lo = clip_acc(longint'(low_int[s]) + round_mul(band_int[s], f_coef));
            hi = clip_acc(round_mul(x, q_root_coef) - longint'(lo)
                          - round_mul(band_int[s], q_coef));
            bd = clip_acc(longint'(band_int[s]) + round_mul(hi, f_coef));
            nt = clip_acc(longint'(hi) + longint'(lo));
            low_int[s]  = lo;
            band_int[s] = bd;
            case (ftype)
                FT_HIGH:  x = hi;
                FT_BAND:  x = bd;
                FT_NOTCH: x = nt;
                default:  x = lo;
            endcase
        end
        y = round_mul(x, gain);
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        if (y < -64'sd8388608)
            y = -64'sd8388608;
        return y[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_coef      = 16'd32768;
            q_coef      = 17'd65536;
            q_root_coef = 17'd65536;
            ftype       = FT_LOW;
            count       = '0;
            gain        = 20'd65536;
            clear_integrators();
            expected_samples.delete();
            in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEF_F:      f_coef      = cfg_data[15:0];
                    REG_COEF_Q:      q_coef      = cfg_data[16:0];
                    REG_COEF_Q_ROOT: q_root_coef = cfg_data[16:0];
                    REG_FILTER_TYPE: ftype       = cfg_data[2:0];
                    REG_STAGE_COUNT:
                    begin
                        count = cfg_data[2:0];
                        clear_integrators();
                    end
                    REG_OUT_GAIN:    gain        = cfg_data[19:0];
                    default: ;
                endcase
            end
            // Compare before queueing, so a word appearing with nothing pending
            // cannot be matched against a sample taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                    flag_error($sformatf("output word %0d with no sample pending",
                                         sample_out));
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                        flag_error($sformatf("sample_out %0d, expected %0d",
                                             sample_out, want));
                end
            end
            if (in_valid && in_ready)
                expected_samples.push_back(filter_sample(sample_in));
            in_flight <= expected_samples.size();
        end
    end

endmodule

### tb/testbench.sv
// Top level of the cascaded state-variable filter testbench: clock, reset,
// stimulus on the three channels and the verdict. Depends on csvf_pkg,
// cascaded_state_variable_filter and csvf_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import csvf_pkg::*;

    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    // Filter type codes outside the defined set; they fall back to low-pass.
    localparam logic [2:0] FT_RSVD_5 = 3'd5;
    localparam logic [2:0] FT_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1450;
    // The tail allows for a word to pass through all six stages.
    localparam int TAIL_CYCLES  = 80;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [SAMPLE_W-1:0]   sample_in;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [SAMPLE_W-1:0]   sample_out;

    int mismatch_count;
    int in_flight;
    int cycle_count = 0;
    int random_sent = 0;
    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;

    cascaded_state_variable_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    csvf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_in       (sample_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample_out      (sample_out),
        .mismatch_count  (mismatch_count),
        .words_in_flight (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Fills the bits above a register's width with random junk, which the
    // block has to discard.
    function automatic logic [CFG_DATA_W-1:0] pad(input logic [CFG_DATA_W-1:0] value,
                                                  input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << width) - 1'b1;
        return (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
    endfunction

    // Mostly full-scale random audio, with the rails and small values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int v;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:
            begin
                v = $urandom_range(0, 2047);
                return SAMPLE_W'(v - 1024);
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Holds valid for the current word until it has been taken; the caller
    // drops valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every predicted word has come out.
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Reprograms the filter with the block idle. Leaving out the stage count
    // keeps the integrators running across the change.
    task automatic set_phase(input logic [15:0] f, input logic [16:0] q,
                             input logic [16:0] q_root, input logic [2:0] ftype,
                             input logic [2:0] stages, input logic [19:0] gain,
                             input bit write_count);
        drain(SETTLE);
        write_reg(REG_COEF_F, pad(CFG_DATA_W'(f), 16));
        write_reg(REG_COEF_Q, pad(CFG_DATA_W'(q), 17));
        write_reg(REG_COEF_Q_ROOT, pad(CFG_DATA_W'(q_root), 17));
        write_reg(REG_FILTER_TYPE, pad(CFG_DATA_W'(ftype), 3));
        if (write_count)
            write_reg(REG_STAGE_COUNT, pad(CFG_DATA_W'(stages), 3));
        write_reg(REG_OUT_GAIN, gain);
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Output side: for each word it draws a stall. With a stall it holds ready
    // low until a word is offered and then through the drawn stall;
    // without one, ready stays high.
    initial
    begin : sink
        int stall;
        out_ready <= 1'b0;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid)
                    @(posedge clk);
                repeat (stall - 1) @(posedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] f_val;
        logic [16:0] q_val;
        logic [16:0] qr_val;
        logic [19:0] gain_val;
        logic [2:0]  stage_val;
        int          run_len;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COEF_F;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample_in <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one low-pass stage, unit gain.
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-24'sd1);

        // Undamped filter with f at its top and the input scale above one:
        // the integrators run into saturation. The stage count is past
        // MAX_STAGES and must be clamped; the gain is at its top.
        set_phase(16'hffff, 17'd0, 17'h1ffff, FT_HIGH, 3'(MAX_STAGES + 2),
                  20'hfffff, 1'b1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // Integrators kept from the phase before; f of zero freezes them.
        set_phase(16'd0, 17'h1ffff, 17'd0, FT_BAND, 3'd0, 20'd65536, 1'b0);
        send_sample(24'sh555555);
        send_sample(24'shaaaaaa);

        // Notch at the largest legal cascade, muted by a zero gain.
        set_phase(16'd12000, 17'd65536, 17'd65536, FT_NOTCH, 3'(MAX_STAGES),
                  20'd0, 1'b1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // Filter types outside the defined set fall back to low-pass.
        set_phase(16'd20000, 17'd30000, 17'd45000, FT_RSVD_5, 3'(MAX_STAGES + 1),
                  20'd131072, 1'b1);
        send_sample(SAMPLE_MAX);
        send_sample(24'sd1000);
        send_sample(SAMPLE_MIN);
        set_phase(16'd8000, 17'd46341, 17'd55109, FT_RSVD_7, 3'd1, 20'd65536, 1'b1);
        send_sample(24'sh123456);
        send_sample(-24'sd4096);

        set_phase(16'd32768, 17'd65536, 17'd65536, FT_LOW, 3'd0, 20'd65536, 1'b1);
        send_sample(24'sd1);
        send_sample(-24'sd2);

        // Random phases: each one draws a fresh setting, with the extremes
        // favored, and then a run of audio.
        while (random_sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 3))
                0:       f_val = 16'hffff;
                1:       f_val = 16'($urandom_range(0, 65535));
                default: f_val = 16'($urandom_range(500, 20000));
            endcase
            case ($urandom_range(0, 4))
                0:       q_val = 17'd0;
                1:       q_val = 17'd65536;
                2:       q_val = 17'h1ffff;
                default: q_val = 17'($urandom_range(8000, 65536));
            endcase
            case ($urandom_range(0, 4))
                0:       qr_val = 17'd0;
                1:       qr_val = 17'd65536;
                2:       qr_val = 17'($urandom_range(65537, 131071));
                default: qr_val = 17'($urandom_range(8000, 65536));
            endcase
            case ($urandom_range(0, 4))
                0:       gain_val = 20'd0;
                1:       gain_val = 20'hfffff;
                2:       gain_val = 20'($urandom);
                default: gain_val = 20'($urandom_range(16384, 262144));
            endcase
            // Long cascades are slow, so most phases keep them short.
            stage_val = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7))
                                                   : 3'($urandom_range(0, 3));
            set_phase(f_val, q_val, qr_val, 3'($urandom_range(0, 7)), stage_val,
                      gain_val, $urandom_range(0, 3) != 0);
            run_len = $urandom_range(10, 60);
            repeat (run_len)
            begin
                // Now and then the source goes quiet until the filter is empty.
                if ($urandom_range(0, 199) == 0)
                    drain(0);
                send_sample(draw_sample());
                random_sent++;
            end
        end

        drain(TAIL_CYCLES);
        if (mismatch_count == 0 && in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
src/csvf_pkg.sv
src/csvf_ram.sv
src/csvf_core.sv
src/cascaded_state_variable_filter.sv
tb/csvf_checker.sv
tb/testbench.sv
